/* hdl/isbp_pkg.sv */
`timescale 1ns / 1ps
package isbp_pkg;

    localparam int BATCH_DEPTH_DEF = 19;

    typedef logic [1:0] t_opcode;
    localparam t_opcode OP_POLL       = 2'd0;
    localparam t_opcode OP_CONNECT    = 2'd1;
    localparam t_opcode OP_DISCONNECT = 2'd2;

    typedef logic [1:0] t_cfg_index;
    localparam t_cfg_index CFG_LINK_MTU      = 2'd0;
    localparam t_cfg_index CFG_FLUSH_TIMEOUT = 2'd1;
    localparam t_cfg_index CFG_STATUS_PERIOD = 2'd2;

    localparam logic [7:0]  MTU_RESET     = 8'd23;
    localparam logic [9:0]  FLUSH_RESET   = 10'd15;
    localparam logic [15:0] STATUS_RESET  = 16'd1000;
    localparam logic [7:0]  MTU_OVERHEAD  = 8'd15;
    localparam logic [7:0]  MTU_MIN       = 8'd27;
    // x / 12 == (x * 171) >> 11 for every x up to 240
    localparam logic [15:0] RECIP_12      = 16'd171;
    localparam int          RECIP_SHIFT   = 11;
    localparam logic [5:0]  CAP_MIN       = 6'd1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EVAL,
        ST_HDR,
        ST_SMP
    } t_state;

    typedef struct packed {
        logic [5:0]  cap;
        logic [9:0]  flush_timeout;
        logic [15:0] status_period;
    } t_cfg;

    function automatic logic [5:0] cap_of_mtu(input logic [7:0] mtu);
        logic [7:0]  x;
        logic [15:0] p;
        x = mtu - MTU_OVERHEAD;
        p = 16'(x) * RECIP_12;
        if (mtu < MTU_MIN) begin
            return CAP_MIN;
        end
        return {1'b0, p[RECIP_SHIFT+4:RECIP_SHIFT]};
    endfunction

endpackage

/* hdl/isbp_sample_ram.sv */
`timescale 1ns / 1ps
module isbp_sample_ram #(
    parameter int DEPTH = 19,
    parameter int IW    = 5,
    parameter int DW    = 96
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [IW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic [IW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata <= mem[i_raddr];
    end

endmodule

/* hdl/isbp_ctrl.sv */
`timescale 1ns / 1ps
module isbp_ctrl #(
    parameter int DEPTH = 19,
    parameter int IW    = 5,
    parameter int CW    = 5
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  isbp_pkg::t_cfg    i_cfg,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [1:0]        i_opcode,
    input  logic              i_sample_valid,
    input  logic [47:0]       i_accel_xyz,
    input  logic [47:0]       i_gyro_xyz,
    input  logic [31:0]       i_time_us,
    input  logic [31:0]       i_time_ms,
    input  logic              i_charging,
    input  logic [6:0]        i_battery_pct,
    input  logic [15:0]       i_battery_mv,
    input  logic              i_link_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic              o_is_header,
    output logic [31:0]       o_first_index,
    output logic [31:0]       o_first_time_us,
    output logic [7:0]        o_battery_byte,
    output logic [4:0]        o_sample_total,
    output logic [15:0]       o_cell_mv,
    output logic [47:0]       o_out_accel,
    output logic [47:0]       o_out_gyro,
    output logic              o_last,
    output logic              o_ram_we,
    output logic [IW-1:0]     o_ram_waddr,
    output logic [95:0]       o_ram_wdata,
    output logic [IW-1:0]     o_ram_raddr,
    input  logic [95:0]       i_ram_rdata
);
    import isbp_pkg::*;

    t_state r_state, n_state;

    // captured item
    logic [1:0]  r_op;
    logic        r_sv;
    logic [47:0] r_accel, r_gyro;
    logic [31:0] r_tus, r_tms;
    logic        r_chg;
    logic [6:0]  r_pct;
    logic [15:0] r_mv;
    logic        r_rdy;

    logic [CW-1:0] r_count, n_count;
    logic [31:0]   r_running, n_running;
    logic [31:0]   r_first_index, n_first_index;
    logic [31:0]   r_first_time, n_first_time;
    logic [31:0]   r_last_flush, n_last_flush;
    logic [31:0]   r_last_status, n_last_status;
    logic          r_link_up, n_link_up;
    logic          r_status, n_status;
    logic [IW-1:0] r_idx, n_idx;

    logic        r_out_valid, n_out_valid;
    logic        r_out_hdr, n_out_hdr;
    logic [31:0] r_out_index, n_out_index;
    logic [31:0] r_out_time, n_out_time;
    logic [7:0]  r_out_bat, n_out_bat;
    logic [4:0]  r_out_total, n_out_total;
    logic [15:0] r_out_mv, n_out_mv;
    logic [47:0] r_out_accel, n_out_accel;
    logic [47:0] r_out_gyro, n_out_gyro;
    logic        r_out_last, n_out_last;

    logic          take, full, timeout, status_due, out_free, smp_last;
    logic [CW-1:0] cnt_after;

    assign o_in_ready = (r_state == ST_IDLE);
    assign out_free   = !r_out_valid || i_out_ready;

    assign take       = r_sv && (r_count < CW'(DEPTH));
    assign cnt_after  = take ? r_count + CW'(1) : r_count;
    assign full       = 6'(cnt_after) >= i_cfg.cap;
    assign timeout    = (cnt_after != '0) &&
                        ((r_tms - r_last_flush) >= 32'(i_cfg.flush_timeout));
    assign status_due = (r_tms - r_last_status) >= 32'(i_cfg.status_period);
    assign smp_last   = (CW'(r_idx) + CW'(1)) == r_count;

    assign o_ram_waddr = r_count[IW-1:0];
    assign o_ram_wdata = {r_accel, r_gyro};
    // read at the next index so the registered data matches r_idx
    assign o_ram_raddr = n_idx;

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_op    <= i_opcode;
            r_sv    <= i_sample_valid;
            r_accel <= i_accel_xyz;
            r_gyro  <= i_gyro_xyz;
            r_tus   <= i_time_us;
            r_tms   <= i_time_ms;
            r_chg   <= i_charging;
            r_pct   <= i_battery_pct;
            r_mv    <= i_battery_mv;
            r_rdy   <= i_link_ready;
        end
        r_out_hdr   <= n_out_hdr;
        r_out_index <= n_out_index;
        r_out_time  <= n_out_time;
        r_out_bat   <= n_out_bat;
        r_out_total <= n_out_total;
        r_out_mv    <= n_out_mv;
        r_out_accel <= n_out_accel;
        r_out_gyro  <= n_out_gyro;
        r_out_last  <= n_out_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_count       <= '0;
            r_running     <= '0;
            r_first_index <= '0;
            r_first_time  <= '0;
            r_last_flush  <= '0;
            r_last_status <= '0;
            r_link_up     <= 1'b0;
            r_status      <= 1'b0;
            r_idx         <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_count       <= n_count;
            r_running     <= n_running;
            r_first_index <= n_first_index;
            r_first_time  <= n_first_time;
            r_last_flush  <= n_last_flush;
            r_last_status <= n_last_status;
            r_link_up     <= n_link_up;
            r_status      <= n_status;
            r_idx         <= n_idx;
            r_out_valid   <= n_out_valid;
        end
    end

    always_comb begin
        n_state       = r_state;
        n_count       = r_count;
        n_running     = r_running;
        n_first_index = r_first_index;
        n_first_time  = r_first_time;
        n_last_flush  = r_last_flush;
        n_last_status = r_last_status;
        n_link_up     = r_link_up;
        n_status      = r_status;
        n_idx         = r_idx;
        n_out_valid   = r_out_valid && !i_out_ready;
        n_out_hdr     = r_out_hdr;
        n_out_index   = r_out_index;
        n_out_time    = r_out_time;
        n_out_bat     = r_out_bat;
        n_out_total   = r_out_total;
        n_out_mv      = r_out_mv;
        n_out_accel   = r_out_accel;
        n_out_gyro    = r_out_gyro;
        n_out_last    = r_out_last;
        o_ram_we      = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                n_idx = '0;
                if (i_in_valid) begin
                    n_state = ST_EVAL;
                end
            end
            ST_EVAL: begin
                n_state = ST_IDLE;
                if (r_op == OP_CONNECT) begin
                    n_running = '0;
                    n_link_up = 1'b1;
                end else if (r_op == OP_DISCONNECT) begin
                    n_link_up = 1'b0;
                    n_count   = '0;
                end else if (r_op == OP_POLL && r_link_up) begin
                    if (r_chg) begin
                        // discard the batch; status header only
                        n_count = '0;
                        if (status_due) begin
                            n_last_status = r_tms;
                            if (r_rdy) begin
                                n_status = 1'b1;
                                n_state  = ST_HDR;
                            end
                        end
                    end else begin
                        if (take) begin
                            if (r_count == '0) begin
                                n_first_time  = r_tus;
                                n_first_index = r_running;
                            end
                            o_ram_we  = 1'b1;
                            n_count   = cnt_after;
                            n_running = r_running + 32'd1;
                        end
                        if (full || timeout) begin
                            if (r_rdy) begin
                                n_status     = 1'b0;
                                n_last_flush = r_tms;
                                n_state      = ST_HDR;
                            end else if (cnt_after == CW'(DEPTH)) begin
                                // refused while full: drop the batch
                                n_count      = '0;
                                n_last_flush = r_tms;
                            end
                        end
                    end
                end
            end
            ST_HDR: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_hdr   = 1'b1;
                    n_out_index = r_status ? 32'd0 : r_first_index;
                    n_out_time  = r_status ? 32'd0 : r_first_time;
                    n_out_bat   = {r_status, r_pct};
                    n_out_total = r_status ? 5'd0 : 5'(r_count);
                    n_out_mv    = r_mv;
                    n_out_accel = '0;
                    n_out_gyro  = '0;
                    n_out_last  = r_status || (r_count == '0);
                    if (r_status || r_count == '0) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_idx   = '0;
                        n_state = ST_SMP;
                    end
                end
            end
            ST_SMP: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_hdr   = 1'b0;
                    n_out_index = '0;
                    n_out_time  = '0;
                    n_out_bat   = '0;
                    n_out_total = '0;
                    n_out_mv    = '0;
                    n_out_accel = i_ram_rdata[95:48];
                    n_out_gyro  = i_ram_rdata[47:0];
                    n_out_last  = smp_last;
                    if (smp_last) begin
                        n_count = '0;
                        n_idx   = '0;
                        n_state = ST_IDLE;
                    end else begin
                        n_idx = r_idx + IW'(1);
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_out_valid     = r_out_valid;
    assign o_is_header     = r_out_hdr;
    assign o_first_index   = r_out_index;
    assign o_first_time_us = r_out_time;
    assign o_battery_byte  = r_out_bat;
    assign o_sample_total  = r_out_total;
    assign o_cell_mv       = r_out_mv;
    assign o_out_accel     = r_out_accel;
    assign o_out_gyro      = r_out_gyro;
    assign o_last          = r_out_last;

endmodule

/* hdl/imu_sample_batch_packetizer_top.sv */
`timescale 1ns / 1ps
// Channel | Handshake                 | Carries
// in      | i_in_valid / o_in_ready   | opcode, sample, clocks, charger, battery, link_ready
// out     | o_out_valid / i_out_ready | header or sample item of a packet
// cfg     | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// An item that sends nothing is captured, then evaluated; a flush of n samples
// sends a header, then one sample item a cycle from the sample RAM read port
// while i_out_ready does not stall the output register.
// Reset is synchronous; the sample RAM is not cleared, only entries of the
// current batch are read. A stalled output holds the item and the emitter.
module imu_sample_batch_packetizer_top #(
    parameter int BATCH_DEPTH = isbp_pkg::BATCH_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_opcode,
    input  logic        i_sample_valid,
    input  logic [47:0] i_accel_xyz,
    input  logic [47:0] i_gyro_xyz,
    input  logic [31:0] i_time_us,
    input  logic [31:0] i_time_ms,
    input  logic        i_charging,
    input  logic [6:0]  i_battery_pct,
    input  logic [15:0] i_battery_mv,
    input  logic        i_link_ready,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_is_header,
    output logic [31:0] o_first_index,
    output logic [31:0] o_first_time_us,
    output logic [7:0]  o_battery_byte,
    output logic [4:0]  o_sample_total,
    output logic [15:0] o_cell_mv,
    output logic [47:0] o_out_accel,
    output logic [47:0] o_out_gyro,
    output logic        o_last,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);
    import isbp_pkg::*;

    localparam int IW = (BATCH_DEPTH > 1) ? $clog2(BATCH_DEPTH) : 1;
    localparam int CW = $clog2(BATCH_DEPTH + 1);
    localparam logic [5:0] DEPTH6    = 6'(BATCH_DEPTH);
    localparam logic [5:0] CAP_RAW_R = cap_of_mtu(MTU_RESET);
    localparam logic [5:0] CAP_RESET = (CAP_RAW_R > DEPTH6) ? DEPTH6 : CAP_RAW_R;

    logic [5:0]  r_cap;
    logic [9:0]  r_flush_timeout;
    logic [15:0] r_status_period;
    logic [5:0]  cap_raw, cap_wr;
    t_cfg        cfg;

    logic          ram_we;
    logic [IW-1:0] ram_waddr, ram_raddr;
    logic [95:0]   ram_wdata, ram_rdata;

    assign o_cfg_ready = 1'b1;
    assign cap_raw     = cap_of_mtu(i_cfg_data[7:0]);
    assign cap_wr      = (cap_raw > DEPTH6) ? DEPTH6 : cap_raw;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap           <= CAP_RESET;
            r_flush_timeout <= FLUSH_RESET;
            r_status_period <= STATUS_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_LINK_MTU:      r_cap           <= cap_wr;
                CFG_FLUSH_TIMEOUT: r_flush_timeout <= i_cfg_data[9:0];
                CFG_STATUS_PERIOD: r_status_period <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign cfg = '{cap: r_cap, flush_timeout: r_flush_timeout,
                   status_period: r_status_period};

    isbp_ctrl #(
        .DEPTH(BATCH_DEPTH),
        .IW(IW),
        .CW(CW)
    ) u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (cfg),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_opcode        (i_opcode),
        .i_sample_valid  (i_sample_valid),
        .i_accel_xyz     (i_accel_xyz),
        .i_gyro_xyz      (i_gyro_xyz),
        .i_time_us       (i_time_us),
        .i_time_ms       (i_time_ms),
        .i_charging      (i_charging),
        .i_battery_pct   (i_battery_pct),
        .i_battery_mv    (i_battery_mv),
        .i_link_ready    (i_link_ready),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_is_header     (o_is_header),
        .o_first_index   (o_first_index),
        .o_first_time_us (o_first_time_us),
        .o_battery_byte  (o_battery_byte),
        .o_sample_total  (o_sample_total),
        .o_cell_mv       (o_cell_mv),
        .o_out_accel     (o_out_accel),
        .o_out_gyro      (o_out_gyro),
        .o_last          (o_last),
        .o_ram_we        (ram_we),
        .o_ram_waddr     (ram_waddr),
        .o_ram_wdata     (ram_wdata),
        .o_ram_raddr     (ram_raddr),
        .i_ram_rdata     (ram_rdata)
    );

    isbp_sample_ram #(
        .DEPTH(BATCH_DEPTH),
        .IW(IW),
        .DW(96)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

endmodule

/* hdl/isbp_checker.sv */
`timescale 1ns / 1ps
module isbp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic        o_is_header,
    input logic [7:0]  o_battery_byte,
    input logic [4:0]  o_sample_total,
    input logic        o_last
);

    // one item at a time: evaluation follows every accepted item
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input taken again in the cycle after an item");

    // a charging status packet is a lone header with no samples
    a_status_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_battery_byte[7] |->
            o_is_header && o_last && (o_sample_total == 5'd0))
        else $error("malformed status header");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_last))
        else $error("stalled output item changed");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

endmodule

bind imu_sample_batch_packetizer_top isbp_checker u_isbp_checker (.*);

/* tb/tb_top.sv */
`timescale 1ns / 1ps
module tb_top;
    import isbp_pkg::*;

    localparam int         DEPTH            = BATCH_DEPTH_DEF;
    localparam int         BYTES_PER_SAMPLE = 12;
    localparam logic [7:0] CHARGE_FLAG      = 8'h80;
    localparam t_opcode    OP_UNUSED        = 2'd3;
    localparam int         SETTLE_CYCLES    = 12;
    localparam int         LONG_HOLD        = 400;
    localparam int         STALL_LIMIT      = 4000;
    localparam int         MAX_GAP          = 6;
    localparam int         PHASE_ITEMS      = 22;

    typedef struct {
        t_opcode     op;
        logic        smp;
        logic [47:0] accel;
        logic [47:0] gyro;
        logic [31:0] t_us;
        logic [31:0] t_ms;
        logic        chg;
        logic [6:0]  pct;
        logic [15:0] mv;
        logic        link_rdy;
    } t_poll;

    typedef struct {
        logic        is_header;
        logic [31:0] first_index;
        logic [31:0] first_time_us;
        logic [7:0]  battery_byte;
        logic [4:0]  sample_total;
        logic [15:0] cell_mv;
        logic [47:0] accel;
        logic [47:0] gyro;
        logic        last;
    } t_packet_item;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [1:0]  i_opcode;
    logic        i_sample_valid;
    logic [47:0] i_accel_xyz;
    logic [47:0] i_gyro_xyz;
    logic [31:0] i_time_us;
    logic [31:0] i_time_ms;
    logic        i_charging;
    logic [6:0]  i_battery_pct;
    logic [15:0] i_battery_mv;
    logic        i_link_ready;
    logic        o_out_valid;
    logic        i_out_ready;
    logic        o_is_header;
    logic [31:0] o_first_index;
    logic [31:0] o_first_time_us;
    logic [7:0]  o_battery_byte;
    logic [4:0]  o_sample_total;
    logic [15:0] o_cell_mv;
    logic [47:0] o_out_accel;
    logic [47:0] o_out_gyro;
    logic        o_last;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [15:0] i_cfg_data;

    imu_sample_batch_packetizer_top u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_opcode        (i_opcode),
        .i_sample_valid  (i_sample_valid),
        .i_accel_xyz     (i_accel_xyz),
        .i_gyro_xyz      (i_gyro_xyz),
        .i_time_us       (i_time_us),
        .i_time_ms       (i_time_ms),
        .i_charging      (i_charging),
        .i_battery_pct   (i_battery_pct),
        .i_battery_mv    (i_battery_mv),
        .i_link_ready    (i_link_ready),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_is_header     (o_is_header),
        .o_first_index   (o_first_index),
        .o_first_time_us (o_first_time_us),
        .o_battery_byte  (o_battery_byte),
        .o_sample_total  (o_sample_total),
        .o_cell_mv       (o_cell_mv),
        .o_out_accel     (o_out_accel),
        .o_out_gyro      (o_out_gyro),
        .o_last          (o_last),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // packetizer state mirror
    logic [47:0]  pk_accel [DEPTH];
    logic [47:0]  pk_gyro  [DEPTH];
    int unsigned  pk_count;
    logic [31:0]  pk_run_index;
    logic [31:0]  pk_first_index;
    logic [31:0]  pk_first_us;
    logic [31:0]  pk_flush_ms;
    logic [31:0]  pk_status_ms;
    logic         pk_linked;
    logic [7:0]   pk_mtu;
    logic [9:0]   pk_timeout;
    logic [15:0]  pk_period;

    t_packet_item due_items [$];
    t_packet_item head_item;

    int unsigned  err_count   = 0;
    int unsigned  quiet_cycles = 0;
    logic         no_idle     = 1'b0;
    logic         hold_req    = 1'b0;
    logic [31:0]  ms_now      = '0;
    int unsigned  ms_stride   = 0;
    logic         ms_jumps    = 1'b0;

    function automatic int unsigned batch_capacity(input logic [7:0] mtu);
        int unsigned c;
        c = (mtu >= MTU_MIN) ? (int'(mtu) - int'(MTU_OVERHEAD)) / BYTES_PER_SAMPLE : 1;
        if (c > DEPTH) c = DEPTH;
        if (c < 1) c = 1;
        return c;
    endfunction

    task automatic queue_item(input logic hdr, input logic [31:0] idx, input logic [31:0] t_us,
                              input logic [7:0] bat, input logic [4:0] n,
                              input logic [15:0] mv, input logic [47:0] a,
                              input logic [47:0] g, input logic last);
        t_packet_item it;
        it.is_header     = hdr;
        it.first_index   = idx;
        it.first_time_us = t_us;
        it.battery_byte  = bat;
        it.sample_total  = n;
        it.cell_mv       = mv;
        it.accel         = a;
        it.gyro          = g;
        it.last          = last;
        due_items.push_back(it);
    endtask

    task automatic predict_packets(input t_poll p);
        int unsigned cap;
        int unsigned n;
        logic        full;
        logic        timed_out;
        case (p.op)
            OP_CONNECT: begin
                pk_run_index = '0;
                pk_linked    = 1'b1;
            end
            OP_DISCONNECT: begin
                pk_linked = 1'b0;
                pk_count  = 0;
            end
            OP_POLL: begin
                if (pk_linked) begin
                    if (p.chg) begin
                        // charging: discard the batch, status header at the period
                        pk_count = 0;
                        if ((p.t_ms - pk_status_ms) >= 32'(pk_period)) begin
                            pk_status_ms = p.t_ms;
                            if (p.link_rdy) begin
                                queue_item(1'b1, '0, '0, CHARGE_FLAG | {1'b0, p.pct}, '0,
                                           p.mv, '0, '0, 1'b1);
                            end
                        end
                    end else begin
                        if (p.smp && pk_count < DEPTH) begin
                            if (pk_count == 0) begin
                                pk_first_us    = p.t_us;
                                pk_first_index = pk_run_index;
                            end
                            pk_accel[pk_count] = p.accel;
                            pk_gyro[pk_count]  = p.gyro;
                            pk_count++;
                            pk_run_index++;
                        end
                        cap       = batch_capacity(pk_mtu);
                        full      = pk_count >= cap;
                        timed_out = pk_count > 0 && (p.t_ms - pk_flush_ms) >= 32'(pk_timeout);
                        if (full || timed_out) begin
                            if (p.link_rdy) begin
                                n = pk_count;
                                queue_item(1'b1, pk_first_index, pk_first_us, {1'b0, p.pct},
                                           5'(n), p.mv, '0, '0, n == 0);
                                for (int i = 0; i < n; i++) begin
                                    queue_item(1'b0, '0, '0, '0, '0, '0, pk_accel[i],
                                               pk_gyro[i], i + 1 == n);
                                end
                                pk_count    = 0;
                                pk_flush_ms = p.t_ms;
                            end else if (pk_count >= DEPTH) begin
                                // refused while full: drop the batch
                                pk_count    = 0;
                                pk_flush_ms = p.t_ms;
                            end
                        end
                    end
                end
            end
            default: ;
        endcase
    endtask

    function automatic logic chance(input int unsigned pct);
        return $urandom_range(0, 99) < pct;
    endfunction

    function automatic t_poll next_poll(input t_opcode op, input logic smp, input logic chg,
                                        input logic rdy);
        t_poll p;
        ms_now += $urandom_range(0, ms_stride);
        if (ms_jumps && $urandom_range(0, 39) == 0) ms_now += $urandom;
        p.op       = op;
        p.smp      = smp;
        p.accel    = 48'({$urandom, $urandom});
        p.gyro     = 48'({$urandom, $urandom});
        p.t_us     = $urandom;
        p.t_ms     = ms_now;
        p.chg      = chg;
        p.pct      = 7'($urandom);
        p.mv       = 16'($urandom);
        p.link_rdy = rdy;
        return p;
    endfunction

    task automatic send_poll(input t_poll p);
        int unsigned gap;
        gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_opcode       <= p.op;
        i_sample_valid <= p.smp;
        i_accel_xyz    <= p.accel;
        i_gyro_xyz     <= p.gyro;
        i_time_us      <= p.t_us;
        i_time_ms      <= p.t_ms;
        i_charging     <= p.chg;
        i_battery_pct  <= p.pct;
        i_battery_mv   <= p.mv;
        i_link_ready   <= p.link_rdy;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        predict_packets(p);
    endtask

    // hold the sender until every expected item is out, then let the block settle
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (due_items.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_index idx, input logic [15:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            CFG_LINK_MTU:      pk_mtu     = data[7:0];
            CFG_FLUSH_TIMEOUT: pk_timeout = data[9:0];
            CFG_STATUS_PERIOD: pk_period  = data;
            default: ;
        endcase
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic configure(input logic [7:0] mtu, input logic [9:0] timeout,
                             input logic [15:0] period);
        wait_drained();
        write_reg(CFG_LINK_MTU, 16'(mtu));
        write_reg(CFG_FLUSH_TIMEOUT, 16'(timeout));
        write_reg(CFG_STATUS_PERIOD, period);
    endtask

    task automatic test_directed_cases();
        t_poll p;
        ms_stride = 0;
        ms_jumps  = 1'b0;
        ms_now    = 32'hFFFF_FFF0;
        // not connected: ignored
        send_poll(next_poll(OP_POLL, 1'b1, 1'b0, 1'b1));
        send_poll(next_poll(OP_UNUSED, 1'b1, 1'b0, 1'b1));
        send_poll(next_poll(OP_CONNECT, 1'b0, 1'b0, 1'b1));
        p = next_poll(OP_POLL, 1'b1, 1'b0, 1'b1);
        p.accel = '1;
        p.gyro  = '1;
        p.t_us  = '1;
        p.pct   = '1;
        p.mv    = '1;
        send_poll(p);
        // refused: batch kept for the next poll
        p = next_poll(OP_POLL, 1'b1, 1'b0, 1'b0);
        p.accel = '0;
        p.gyro  = '0;
        p.t_us  = '0;
        p.pct   = '0;
        p.mv    = '0;
        send_poll(p);
        ms_now = 32'd3;
        send_poll(next_poll(OP_POLL, 1'b0, 1'b0, 1'b1));
        send_poll(next_poll(OP_POLL, 1'b0, 1'b0, 1'b1));
        // charging status: sent, too early, lost, sent on the boundary
        ms_now = 32'd2000;
        send_poll(next_poll(OP_POLL, 1'b1, 1'b1, 1'b1));
        ms_now = 32'd2500;
        send_poll(next_poll(OP_POLL, 1'b1, 1'b1, 1'b1));
        ms_now = 32'd3100;
        send_poll(next_poll(OP_POLL, 1'b0, 1'b1, 1'b0));
        ms_now = 32'd4100;
        send_poll(next_poll(OP_POLL, 1'b0, 1'b1, 1'b1));
        send_poll(next_poll(OP_CONNECT, 1'b0, 1'b0, 1'b1));
        configure(8'd247, 10'd1000, 16'd1000);
        ms_now = 32'd4200;
        send_poll(next_poll(OP_POLL, 1'b1, 1'b0, 1'b1));
        ms_now = 32'd4210;
        send_poll(next_poll(OP_POLL, 1'b1, 1'b0, 1'b1));
        ms_now = 32'd4220;
        send_poll(next_poll(OP_POLL, 1'b1, 1'b0, 1'b1));
        send_poll(next_poll(OP_DISCONNECT, 1'b0, 1'b0, 1'b1));
        send_poll(next_poll(OP_POLL, 1'b1, 1'b0, 1'b1));
        send_poll(next_poll(OP_CONNECT, 1'b0, 1'b0, 1'b1));
        ms_now = 32'd4300;
        send_poll(next_poll(OP_POLL, 1'b1, 1'b0, 1'b1));
        // flush timeout one short of the limit, then on it
        ms_now = 32'd5199;
        send_poll(next_poll(OP_POLL, 1'b0, 1'b0, 1'b1));
        ms_now = 32'd5200;
        send_poll(next_poll(OP_POLL, 1'b0, 1'b0, 1'b1));
    endtask

    task automatic run_phase(input logic [7:0] mtu, input logic [9:0] timeout,
                             input logic [15:0] period, input int unsigned stride,
                             input int unsigned rdy_pct, input int unsigned chg_pct);
        int unsigned pick;
        int unsigned chg_left;
        configure(mtu, timeout, period);
        ms_stride = stride;
        chg_left  = 0;
        send_poll(next_poll(OP_CONNECT, 1'b0, 1'b0, 1'b1));
        for (int k = 0; k < PHASE_ITEMS; k++) begin
            pick = $urandom_range(0, 99);
            if (chg_left > 0) begin
                chg_left--;
                send_poll(next_poll(OP_POLL, 1'($urandom), 1'b1, chance(rdy_pct)));
            end else if (pick < 2) begin
                // drop the link, let a few polls go unheard, then reconnect
                send_poll(next_poll(OP_DISCONNECT, 1'b0, 1'b0, 1'b1));
                repeat ($urandom_range(0, 2)) send_poll(next_poll(OP_POLL, 1'b1, 1'b0, 1'b1));
                send_poll(next_poll(OP_CONNECT, 1'b0, 1'b0, 1'b1));
            end else if (pick < 4) begin
                send_poll(next_poll(OP_CONNECT, 1'($urandom), 1'b0, 1'b1));
            end else if (pick < 5) begin
                send_poll(next_poll(OP_UNUSED, 1'($urandom), 1'($urandom), 1'($urandom)));
            end else if (pick < 5 + chg_pct) begin
                chg_left = $urandom_range(2, 6);
            end else begin
                send_poll(next_poll(OP_POLL, chance(85), 1'b0, chance(rdy_pct)));
            end
        end
    endtask

    task automatic test_random_traffic();
        ms_jumps = 1'b1;
        run_phase(8'd23,  10'd15,   16'd1000,  5,  85, 3);
        run_phase(8'd247, 10'd1000, 16'd65535, 40, 60, 3);
        run_phase(8'd27,  10'd1,    16'd1,     2,  80, 8);
        no_idle = 1'b1;
        run_phase(8'd63,  10'd20,   16'd50,    8,  90, 5);
        no_idle = 1'b0;
        run_phase(8'd26,  10'd500,  16'd2,     60, 70, 6);
        run_phase(8'd135, 10'd100,  16'd300,   20, 85, 4);
        run_phase(8'd243, 10'd999,  16'd65535, 40, 35, 2);
        run_phase(8'd200, 10'd7,    16'd10,    3,  75, 5);
    endtask

    task automatic test_output_stall();
        configure(8'd100, 10'd1000, 16'd1000);
        ms_stride = 1;
        send_poll(next_poll(OP_CONNECT, 1'b0, 1'b0, 1'b1));
        hold_req = 1'b1;
        no_idle  = 1'b1;
        for (int k = 0; k < 40; k++) begin
            send_poll(next_poll(OP_POLL, 1'b1, 1'b0, 1'b1));
        end
        wait_drained();
        no_idle = 1'b0;
    endtask

    // result receiver
    initial begin
        int unsigned stall;
        i_out_ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                i_out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end
            stall = no_idle ? 0 : $urandom_range(0, MAX_GAP);
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            @(posedge i_clk);
            while (!o_out_valid && !hold_req) @(posedge i_clk);
        end
    end

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want) begin
            err_count++;
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        if (o_out_valid && i_out_ready) begin
            if (due_items.size() == 0) begin
                err_count++;
                $display("%0t: unexpected item, expected none, actual header %0b accel 0x%0h",
                         $time, o_is_header, o_out_accel);
            end else begin
                head_item = due_items.pop_front();
                check_field("is_header", 64'(head_item.is_header), 64'(o_is_header));
                check_field("first_index", 64'(head_item.first_index), 64'(o_first_index));
                check_field("first_time_us", 64'(head_item.first_time_us),
                            64'(o_first_time_us));
                check_field("battery_byte", 64'(head_item.battery_byte), 64'(o_battery_byte));
                check_field("sample_total", 64'(head_item.sample_total), 64'(o_sample_total));
                check_field("cell_mv", 64'(head_item.cell_mv), 64'(o_cell_mv));
                check_field("out_accel", 64'(head_item.accel), 64'(o_out_accel));
                check_field("out_gyro", 64'(head_item.gyro), 64'(o_out_gyro));
                check_field("last", 64'(head_item.last), 64'(o_last));
            end
        end
    end

    // end the run if no channel moves an item for too long
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, quiet_cycles);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        i_rst_n        <= 1'b0;
        i_in_valid     <= 1'b0;
        i_opcode       <= OP_POLL;
        i_sample_valid <= 1'b0;
        i_accel_xyz    <= '0;
        i_gyro_xyz     <= '0;
        i_time_us      <= '0;
        i_time_ms      <= '0;
        i_charging     <= 1'b0;
        i_battery_pct  <= '0;
        i_battery_mv   <= '0;
        i_link_ready   <= 1'b0;
        i_cfg_valid    <= 1'b0;
        i_cfg_index    <= CFG_LINK_MTU;
        i_cfg_data     <= '0;
        pk_count       = 0;
        pk_run_index   = '0;
        pk_first_index = '0;
        pk_first_us    = '0;
        pk_flush_ms    = '0;
        pk_status_ms   = '0;
        pk_linked      = 1'b0;
        pk_mtu         = MTU_RESET;
        pk_timeout     = FLUSH_RESET;
        pk_period      = STATUS_RESET;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_cases();
        test_random_traffic();
        test_output_stall();
        wait_drained();

        if (err_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
